// ===== hdl/ccp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ccp_pkg
// Shared widths, types and constants of the circumcircle pipeline.
// ----------------------------------------------------------------------------
package ccp_pkg;

    localparam int COORD_BITS = 13;
    localparam int FRAC_BITS  = 8;

    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int SQ_W       = 2 * COORD_BITS + 1;
    localparam int PROD_W     = COORD_BITS + DIFF_W;
    localparam int DEN_W      = PROD_W + 3;
    localparam int NP_W       = SQ_W + DIFF_W;
    localparam int NUM_W      = NP_W + 2;
    localparam int DVD_W      = NUM_W + FRAC_BITS;
    localparam int DIV_STEPS  = DVD_W;
    localparam int DLT_W      = DVD_W + 2;
    localparam int CENTER_W   = 24;
    localparam int RADIUS_W   = 31;
    localparam int SQRT_STEPS = RADIUS_W + 1;
    localparam int SQIN_W     = 2 * SQRT_STEPS;

    localparam int S_TDATA_W  = ((6 * COORD_BITS + 7) / 8) * 8;
    localparam int M_FIELDS_W = 2 * CENTER_W + RADIUS_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    typedef logic signed [COORD_BITS-1:0]   coord_t;
    typedef logic signed [DIFF_W-1:0]       diff_t;
    typedef logic signed [2*COORD_BITS-1:0] sqr_t;
    typedef logic signed [SQ_W-1:0]         ssum_t;
    typedef logic signed [PROD_W-1:0]       prod_t;
    typedef logic signed [DEN_W-1:0]        den_t;
    typedef logic signed [NP_W-1:0]         np_t;
    typedef logic signed [NUM_W-1:0]        num_t;
    typedef logic        [DVD_W-1:0]        dvd_t;
    typedef logic        [DEN_W-1:0]        denm_t;
    typedef logic signed [CENTER_W-1:0]     center_t;
    typedef logic        [RADIUS_W-1:0]     radius_t;
    typedef logic        [SQIN_W-1:0]       sqin_t;
    typedef logic        [SQRT_STEPS-1:0]   root_t;

    localparam radius_t RADIUS_MAX = '1;

    typedef struct packed {
        logic   nz;
        logic   neg_a;
        logic   neg_b;
        coord_t x1;
        coord_t y1;
    } div_side_t;

    typedef struct packed {
        dvd_t      dvd_a;
        dvd_t      dvd_b;
        denm_t     den;
        div_side_t side;
    } div_in_t;

    typedef struct packed {
        dvd_t      q_a;
        dvd_t      q_b;
        div_side_t side;
    } div_out_t;

    typedef struct packed {
        logic    nz;
        logic    sat;
        center_t cx;
        center_t cy;
    } sq_side_t;

    typedef struct packed {
        sqin_t    n;
        sq_side_t side;
    } sq_in_t;

    typedef struct packed {
        root_t    root;
        sq_side_t side;
    } sq_out_t;

    typedef struct packed {
        logic    valid_res;
        center_t cx;
        center_t cy;
        radius_t radius;
    } res_t;

endpackage
`default_nettype wire

// ===== hdl/ccp_setup.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ccp_setup
// Five stages that form the doubled determinant and the center numerators.
// ----------------------------------------------------------------------------
module ccp_setup
    import ccp_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    en,
    input  wire logic    in_valid,
    input  wire coord_t  x1,
    input  wire coord_t  y1,
    input  wire coord_t  x2,
    input  wire coord_t  y2,
    input  wire coord_t  x3,
    input  wire coord_t  y3,
    output logic         out_valid,
    output div_in_t      out_data
);

    logic [4:0] v_reg;

    // Stage 1: differences and squares.
    coord_t a_x1_reg, a_y1_reg, a_x2_reg, a_x3_reg;
    diff_t  a_dy23_reg, a_dy31_reg, a_dy12_reg, a_dx32_reg, a_dx13_reg, a_dx21_reg;
    sqr_t   a_qx1_reg, a_qy1_reg, a_qx2_reg, a_qy2_reg, a_qx3_reg, a_qy3_reg;
    // Stage 2: sums of squares and determinant products.
    coord_t b_x1_reg, b_y1_reg;
    diff_t  b_dy23_reg, b_dy31_reg, b_dy12_reg, b_dx32_reg, b_dx13_reg, b_dx21_reg;
    ssum_t  b_s1_reg, b_s2_reg, b_s3_reg;
    prod_t  b_p1_reg, b_p2_reg, b_p3_reg;
    // Stage 3: determinant and numerator products.
    coord_t c_x1_reg, c_y1_reg;
    den_t   c_den_reg;
    np_t    c_a1_reg, c_a2_reg, c_a3_reg, c_b1_reg, c_b2_reg, c_b3_reg;
    // Stage 4: numerators.
    coord_t d_x1_reg, d_y1_reg;
    den_t   d_den_reg;
    num_t   d_na_reg, d_nb_reg;
    logic   d_nz_reg;
    // Stage 5: magnitudes and signs for the divider.
    div_in_t e_reg;

    den_t    den_sum;
    div_in_t e_next;
    num_t    ma, mb;

    always_comb begin
        den_sum = den_t'(b_p1_reg) + den_t'(b_p2_reg) + den_t'(b_p3_reg);
        ma = d_na_reg[NUM_W-1] ? -d_na_reg : d_na_reg;
        mb = d_nb_reg[NUM_W-1] ? -d_nb_reg : d_nb_reg;
        e_next.dvd_a      = dvd_t'(NUM_W'(ma)) << FRAC_BITS;
        e_next.dvd_b      = dvd_t'(NUM_W'(mb)) << FRAC_BITS;
        e_next.den        = d_den_reg[DEN_W-1] ? denm_t'(-d_den_reg) : denm_t'(d_den_reg);
        e_next.side.nz    = d_nz_reg;
        e_next.side.neg_a = d_na_reg[NUM_W-1] ^ d_den_reg[DEN_W-1];
        e_next.side.neg_b = d_nb_reg[NUM_W-1] ^ d_den_reg[DEN_W-1];
        e_next.side.x1    = d_x1_reg;
        e_next.side.y1    = d_y1_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_x1_reg   <= x1;
            a_y1_reg   <= y1;
            a_x2_reg   <= x2;
            a_x3_reg   <= x3;
            a_dy23_reg <= diff_t'(y2) - diff_t'(y3);
            a_dy31_reg <= diff_t'(y3) - diff_t'(y1);
            a_dy12_reg <= diff_t'(y1) - diff_t'(y2);
            a_dx32_reg <= diff_t'(x3) - diff_t'(x2);
            a_dx13_reg <= diff_t'(x1) - diff_t'(x3);
            a_dx21_reg <= diff_t'(x2) - diff_t'(x1);
            a_qx1_reg  <= sqr_t'(x1) * sqr_t'(x1);
            a_qy1_reg  <= sqr_t'(y1) * sqr_t'(y1);
            a_qx2_reg  <= sqr_t'(x2) * sqr_t'(x2);
            a_qy2_reg  <= sqr_t'(y2) * sqr_t'(y2);
            a_qx3_reg  <= sqr_t'(x3) * sqr_t'(x3);
            a_qy3_reg  <= sqr_t'(y3) * sqr_t'(y3);

            b_x1_reg   <= a_x1_reg;
            b_y1_reg   <= a_y1_reg;
            b_dy23_reg <= a_dy23_reg;
            b_dy31_reg <= a_dy31_reg;
            b_dy12_reg <= a_dy12_reg;
            b_dx32_reg <= a_dx32_reg;
            b_dx13_reg <= a_dx13_reg;
            b_dx21_reg <= a_dx21_reg;
            b_s1_reg   <= ssum_t'(a_qx1_reg) + ssum_t'(a_qy1_reg);
            b_s2_reg   <= ssum_t'(a_qx2_reg) + ssum_t'(a_qy2_reg);
            b_s3_reg   <= ssum_t'(a_qx3_reg) + ssum_t'(a_qy3_reg);
            b_p1_reg   <= prod_t'(a_x1_reg) * prod_t'(a_dy23_reg);
            b_p2_reg   <= prod_t'(a_x2_reg) * prod_t'(a_dy31_reg);
            b_p3_reg   <= prod_t'(a_x3_reg) * prod_t'(a_dy12_reg);

            c_x1_reg   <= b_x1_reg;
            c_y1_reg   <= b_y1_reg;
            c_den_reg  <= den_sum <<< 1;
            c_a1_reg   <= np_t'(b_s1_reg) * np_t'(b_dy23_reg);
            c_a2_reg   <= np_t'(b_s2_reg) * np_t'(b_dy31_reg);
            c_a3_reg   <= np_t'(b_s3_reg) * np_t'(b_dy12_reg);
            c_b1_reg   <= np_t'(b_s1_reg) * np_t'(b_dx32_reg);
            c_b2_reg   <= np_t'(b_s2_reg) * np_t'(b_dx13_reg);
            c_b3_reg   <= np_t'(b_s3_reg) * np_t'(b_dx21_reg);

            d_x1_reg   <= c_x1_reg;
            d_y1_reg   <= c_y1_reg;
            d_den_reg  <= c_den_reg;
            d_nz_reg   <= (c_den_reg != '0);
            d_na_reg   <= num_t'(c_a1_reg) + num_t'(c_a2_reg) + num_t'(c_a3_reg);
            d_nb_reg   <= num_t'(c_b1_reg) + num_t'(c_b2_reg) + num_t'(c_b3_reg);

            e_reg      <= e_next;
        end
    end

    assign out_valid = v_reg[4];
    assign out_data  = e_reg;

endmodule
`default_nettype wire

// ===== hdl/ccp_divider.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ccp_divider
// Restoring divider, one quotient bit per stage, two lanes sharing the divisor.
// ----------------------------------------------------------------------------
module ccp_divider
    import ccp_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    en,
    input  wire logic    in_valid,
    input  wire div_in_t in_data,
    output logic         out_valid,
    output div_out_t     out_data
);

    typedef logic [DEN_W:0] rem_t;

    typedef struct packed {
        rem_t      rem_a;
        rem_t      rem_b;
        dvd_t      dq_a;
        dvd_t      dq_b;
        denm_t     den;
        div_side_t side;
    } st_t;

    typedef struct packed {
        rem_t rem;
        dvd_t dq;
    } step_t;

    // The low end of dq collects quotient bits while the dividend shifts out the top.
    function automatic step_t div_step(rem_t rem, dvd_t dq, denm_t den);
        rem_t  trial;
        step_t r;
        trial = {rem[DEN_W-1:0], dq[DVD_W-1]};
        if (trial >= {1'b0, den}) begin
            r.rem = trial - {1'b0, den};
            r.dq  = {dq[DVD_W-2:0], 1'b1};
        end else begin
            r.rem = trial;
            r.dq  = {dq[DVD_W-2:0], 1'b0};
        end
        return r;
    endfunction

    logic [DIV_STEPS-1:0] v_reg;
    st_t                  st_reg  [DIV_STEPS];
    st_t                  src     [DIV_STEPS];
    st_t                  st_next [DIV_STEPS];

    always_comb begin
        step_t sa, sb;
        src[0].rem_a = '0;
        src[0].rem_b = '0;
        src[0].dq_a  = in_data.dvd_a;
        src[0].dq_b  = in_data.dvd_b;
        src[0].den   = in_data.den;
        src[0].side  = in_data.side;
        for (int i = 1; i < DIV_STEPS; i++) begin
            src[i] = st_reg[i-1];
        end
        for (int i = 0; i < DIV_STEPS; i++) begin
            sa = div_step(src[i].rem_a, src[i].dq_a, src[i].den);
            sb = div_step(src[i].rem_b, src[i].dq_b, src[i].den);
            st_next[i]       = src[i];
            st_next[i].rem_a = sa.rem;
            st_next[i].dq_a  = sa.dq;
            st_next[i].rem_b = sb.rem;
            st_next[i].dq_b  = sb.dq;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[DIV_STEPS-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < DIV_STEPS; i++) begin
                st_reg[i] <= st_next[i];
            end
        end
    end

    assign out_valid     = v_reg[DIV_STEPS-1];
    assign out_data.q_a  = st_reg[DIV_STEPS-1].dq_a;
    assign out_data.q_b  = st_reg[DIV_STEPS-1].dq_b;
    assign out_data.side = st_reg[DIV_STEPS-1].side;

endmodule
`default_nettype wire

// ===== hdl/ccp_dist.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ccp_dist
// Signs the quotients, saturates the center and forms the squared radius.
// ----------------------------------------------------------------------------
module ccp_dist
    import ccp_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     en,
    input  wire logic     in_valid,
    input  wire div_out_t in_data,
    output logic          out_valid,
    output sq_in_t        out_data
);

    typedef logic signed [DVD_W:0]   fix_t;
    typedef logic signed [DLT_W-1:0] dlt_t;
    typedef logic [2*RADIUS_W-1:0]   sqr2_t;

    localparam dlt_t LIM_POS = dlt_t'({1'b0, RADIUS_MAX});
    localparam dlt_t LIM_NEG = -LIM_POS;
    localparam dvd_t CMAX_POS = dvd_t'({1'b0, {(CENTER_W-1){1'b1}}});
    localparam dvd_t CMAX_NEG = dvd_t'({1'b1, {(CENTER_W-1){1'b0}}});

    // Whole-pixel part of the truncated quotient, clipped to the output range.
    function automatic center_t sat_center(dvd_t q, logic neg);
        dvd_t whole;
        whole = q >> FRAC_BITS;
        if (!neg) begin
            return (whole > CMAX_POS) ? center_t'(CMAX_POS) : center_t'(whole);
        end else begin
            return (whole > CMAX_NEG) ? center_t'(CMAX_NEG) : center_t'(-whole);
        end
    endfunction

    logic [4:0] v_reg;

    fix_t     a_ax_reg, a_by_reg;
    coord_t   a_x1_reg, a_y1_reg;
    sq_side_t a_side_reg;
    dlt_t     b_dx_reg, b_dy_reg;
    sq_side_t b_side_reg;
    radius_t  c_ux_reg, c_uy_reg;
    sq_side_t c_side_reg;
    sqr2_t    d_qx_reg, d_qy_reg;
    sq_side_t d_side_reg;
    sq_in_t   e_reg;

    sq_side_t a_side_next;
    sq_side_t c_side_next;
    dlt_t     ux_full, uy_full;

    always_comb begin
        a_side_next.nz  = in_data.side.nz;
        a_side_next.sat = 1'b0;
        a_side_next.cx  = sat_center(in_data.q_a, in_data.side.neg_a);
        a_side_next.cy  = sat_center(in_data.q_b, in_data.side.neg_b);
        ux_full = b_dx_reg[DLT_W-1] ? -b_dx_reg : b_dx_reg;
        uy_full = b_dy_reg[DLT_W-1] ? -b_dy_reg : b_dy_reg;
        c_side_next     = b_side_reg;
        c_side_next.sat = (b_dx_reg > LIM_POS) || (b_dx_reg < LIM_NEG)
                       || (b_dy_reg > LIM_POS) || (b_dy_reg < LIM_NEG);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_ax_reg   <= in_data.side.neg_a ? -fix_t'(in_data.q_a) : fix_t'(in_data.q_a);
            a_by_reg   <= in_data.side.neg_b ? -fix_t'(in_data.q_b) : fix_t'(in_data.q_b);
            a_x1_reg   <= in_data.side.x1;
            a_y1_reg   <= in_data.side.y1;
            a_side_reg <= a_side_next;

            b_dx_reg   <= (dlt_t'(a_x1_reg) <<< FRAC_BITS) - dlt_t'(a_ax_reg);
            b_dy_reg   <= (dlt_t'(a_y1_reg) <<< FRAC_BITS) - dlt_t'(a_by_reg);
            b_side_reg <= a_side_reg;

            c_ux_reg   <= ux_full[RADIUS_W-1:0];
            c_uy_reg   <= uy_full[RADIUS_W-1:0];
            c_side_reg <= c_side_next;

            d_qx_reg   <= sqr2_t'(c_ux_reg) * sqr2_t'(c_ux_reg);
            d_qy_reg   <= sqr2_t'(c_uy_reg) * sqr2_t'(c_uy_reg);
            d_side_reg <= c_side_reg;

            e_reg      <= {sqin_t'(d_qx_reg) + sqin_t'(d_qy_reg), d_side_reg};
        end
    end

    assign out_valid = v_reg[4];
    assign out_data  = e_reg;

endmodule
`default_nettype wire

// ===== hdl/ccp_sqrt.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ccp_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module ccp_sqrt
    import ccp_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   en,
    input  wire logic   in_valid,
    input  wire sq_in_t in_data,
    output logic        out_valid,
    output sq_out_t     out_data
);

    typedef logic [SQRT_STEPS+1:0] srem_t;

    typedef struct packed {
        srem_t    rem;
        root_t    root;
        sqin_t    n;
        sq_side_t side;
    } st_t;

    logic [SQRT_STEPS-1:0] v_reg;
    st_t                   st_reg  [SQRT_STEPS];
    st_t                   src     [SQRT_STEPS];
    st_t                   st_next [SQRT_STEPS];

    always_comb begin
        srem_t t, trial;
        src[0].rem  = '0;
        src[0].root = '0;
        src[0].n    = in_data.n;
        src[0].side = in_data.side;
        for (int i = 1; i < SQRT_STEPS; i++) begin
            src[i] = st_reg[i-1];
        end
        for (int i = 0; i < SQRT_STEPS; i++) begin
            t     = {src[i].rem[SQRT_STEPS-1:0], src[i].n[SQIN_W-1 -: 2]};
            trial = {src[i].root, 2'b01};
            st_next[i]   = src[i];
            st_next[i].n = src[i].n << 2;
            if (t >= trial) begin
                st_next[i].rem  = t - trial;
                st_next[i].root = {src[i].root[SQRT_STEPS-2:0], 1'b1};
            end else begin
                st_next[i].rem  = t;
                st_next[i].root = {src[i].root[SQRT_STEPS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[SQRT_STEPS-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < SQRT_STEPS; i++) begin
                st_reg[i] <= st_next[i];
            end
        end
    end

    assign out_valid     = v_reg[SQRT_STEPS-1];
    assign out_data.root = st_reg[SQRT_STEPS-1].root;
    assign out_data.side = st_reg[SQRT_STEPS-1].side;

endmodule
`default_nettype wire

// ===== hdl/circumcircle_three_points.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// circumcircle_three_points
// Circle through three integer points: center and fixed-point radius.
// ----------------------------------------------------------------------------
// The block takes one item of three points per clock cycle while s_tready
// is high and returns one result item for each, in order. Five setup stages
// form the doubled determinant and the center numerators exactly, a 51-stage
// restoring divider produces the center with eight fractional bits truncated
// toward zero, five stages form the squared distance to the first point, and
// a 32-stage square root gives the floored radius in units of 1/256 pixel. The
// last stage is an output register backed by one skid register, so s_tready
// stays high while a single finished item waits; it falls only once the skid
// register is full. Collinear points give m_tuser low and all-zero data. The
// center saturates to the signed 24-bit range and the radius to the largest
// 31-bit value.
// ----------------------------------------------------------------------------
module circumcircle_three_points
    import ccp_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // first_x, first_y, second_x, second_y, third_x, third_y, zero pad
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // center_x, center_y, radius_fixed, zero pad
    output logic [M_TDATA_W-1:0]      m_tdata,
    // valid_res
    output logic                      m_tuser
);

    logic     en;
    logic     setup_valid, div_valid, dist_valid, sq_valid;
    div_in_t  setup_data;
    div_out_t div_data;
    sq_in_t   dist_data;
    sq_out_t  sq_data;

    res_t res;
    res_t out_reg, skid_reg;
    logic out_valid_reg, skid_valid_reg;

    // The whole pipeline moves together; it halts only while the skid register
    // holds an item.
    assign en       = !skid_valid_reg;
    assign s_tready = en;

    ccp_setup u_setup (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .x1        (coord_t'(s_tdata[0*COORD_BITS +: COORD_BITS])),
        .y1        (coord_t'(s_tdata[1*COORD_BITS +: COORD_BITS])),
        .x2        (coord_t'(s_tdata[2*COORD_BITS +: COORD_BITS])),
        .y2        (coord_t'(s_tdata[3*COORD_BITS +: COORD_BITS])),
        .x3        (coord_t'(s_tdata[4*COORD_BITS +: COORD_BITS])),
        .y3        (coord_t'(s_tdata[5*COORD_BITS +: COORD_BITS])),
        .out_valid (setup_valid),
        .out_data  (setup_data)
    );

    ccp_divider u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (setup_valid),
        .in_data   (setup_data),
        .out_valid (div_valid),
        .out_data  (div_data)
    );

    ccp_dist u_dist (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (div_valid),
        .in_data   (div_data),
        .out_valid (dist_valid),
        .out_data  (dist_data)
    );

    ccp_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (dist_valid),
        .in_data   (dist_data),
        .out_valid (sq_valid),
        .out_data  (sq_data)
    );

    // Final result. A root above the 31-bit range has its top bit set.
    always_comb begin
        if (sq_data.side.nz) begin
            res.valid_res = 1'b1;
            res.cx        = sq_data.side.cx;
            res.cy        = sq_data.side.cy;
            if (sq_data.side.sat || sq_data.root[SQRT_STEPS-1]) begin
                res.radius = RADIUS_MAX;
            end else begin
                res.radius = sq_data.root[RADIUS_W-1:0];
            end
        end else begin
            res = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_valid_reg && m_tready) begin
            if (skid_valid_reg) begin
                out_reg        <= skid_reg;
                skid_valid_reg <= 1'b0;
            end else if (sq_valid) begin
                out_reg <= res;
            end else begin
                out_valid_reg <= 1'b0;
            end
        end else if (en && sq_valid) begin
            if (!out_valid_reg) begin
                out_reg       <= res;
                out_valid_reg <= 1'b1;
            end else begin
                skid_reg       <= res;
                skid_valid_reg <= 1'b1;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.valid_res;
    assign m_tdata  = M_TDATA_W'({out_reg.radius, out_reg.cy, out_reg.cx});

endmodule
`default_nettype wire

// ===== tb/sv/circumcircle_three_points_tb.sv =====
// ----------------------------------------------------------------------------
// circumcircle_three_points_tb
// Self-checking bench for the circumcircle pipeline.
// ----------------------------------------------------------------------------
// Point triples are streamed into the block with random gaps on the input and
// random stalls on the output. A scoreboard predicts each circle from the
// accepted points with exact integer math and compares every result item, in
// order, field by field.
// ----------------------------------------------------------------------------
module circumcircle_three_points_tb;
    import ccp_pkg::*;

    localparam int PIPE_CYCLES = 94;

    typedef struct {
        logic    ok;
        center_t cx;
        center_t cy;
        radius_t rad;
    } circle_t;

    // Holds the predicted circles and checks arriving results against them.
    class circle_board;
        circle_t pending[$];
        int      errors = 0;

        // Floored square root of a 64-bit value, one result bit per pass.
        function automatic longint unsigned root_floor(longint unsigned n);
            longint unsigned res;
            longint unsigned bitv;
            res = 0;
            bitv = 64'd1 << 62;
            while (bitv > n) bitv >>= 2;
            while (bitv != 0) begin
                if (n >= res + bitv) begin
                    n -= res + bitv;
                    res = (res >> 1) + bitv;
                end else begin
                    res >>= 1;
                end
                bitv >>= 2;
            end
            return res;
        endfunction

        // Center coordinate with FRAC_BITS fraction bits, truncated, clamped.
        function automatic longint center_fixed(longint num, longint den,
                                                output longint whole);
            longint q;
            longint r;
            longint lim;
            q = num / den;
            r = num % den;
            lim = (64'sd1 <<< 47) >>> FRAC_BITS;
            whole = q;
            if (q > lim) return 64'sd1 <<< 47;
            if (q < -lim) return -(64'sd1 <<< 47);
            return q * (64'sd1 <<< FRAC_BITS) + (r * (64'sd1 <<< FRAC_BITS)) / den;
        endfunction

        function automatic center_t clip_center(longint v);
            if (v > 8388607) v = 8388607;
            if (v < -8388608) v = -8388608;
            return center_t'(v);
        endfunction

        function void note_points(coord_t p[6]);
            longint x1, y1, x2, y2, x3, y3, den, s1, s2, s3, na, nb;
            longint qa, qb, ax, by, dx, dy, lim;
            longint unsigned ux, uy, rr;
            circle_t c;
            x1 = p[0]; y1 = p[1]; x2 = p[2]; y2 = p[3]; x3 = p[4]; y3 = p[5];
            lim = 64'sd2147483647;
            den = 2 * (x1 * (y2 - y3) + x2 * (y3 - y1) + x3 * (y1 - y2));
            if (den == 0) begin
                c.ok = 1'b0; c.cx = '0; c.cy = '0; c.rad = '0;
            end else begin
                s1 = x1 * x1 + y1 * y1;
                s2 = x2 * x2 + y2 * y2;
                s3 = x3 * x3 + y3 * y3;
                na = s1 * (y2 - y3) + s2 * (y3 - y1) + s3 * (y1 - y2);
                nb = s1 * (x3 - x2) + s2 * (x1 - x3) + s3 * (x2 - x1);
                ax = center_fixed(na, den, qa);
                by = center_fixed(nb, den, qb);
                dx = x1 * (64'sd1 <<< FRAC_BITS) - ax;
                dy = y1 * (64'sd1 <<< FRAC_BITS) - by;
                if (dx > lim || dx < -lim || dy > lim || dy < -lim) begin
                    rr = 64'd2147483647;
                end else begin
                    ux = dx < 0 ? -dx : dx;
                    uy = dy < 0 ? -dy : dy;
                    rr = root_floor(ux * ux + uy * uy);
                    if (rr > 64'd2147483647) rr = 64'd2147483647;
                end
                c.ok = 1'b1;
                c.cx = clip_center(qa);
                c.cy = clip_center(qb);
                c.rad = radius_t'(rr);
            end
            pending.push_back(c);
        endfunction

        function void check_result(logic ok, center_t cx, center_t cy, radius_t rad);
            circle_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected item, actual ok=%0b cx=%0d cy=%0d r=%0d",
                         $time, ok, cx, cy, rad);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (ok !== e.ok) begin
                $display("%0t: valid_res expected %0b actual %0b", $time, e.ok, ok);
                errors++;
            end
            if (cx !== e.cx) begin
                $display("%0t: center_x expected %0d actual %0d", $time, e.cx, cx);
                errors++;
            end
            if (cy !== e.cy) begin
                $display("%0t: center_y expected %0d actual %0d", $time, e.cy, cy);
                errors++;
            end
            if (rad !== e.rad) begin
                $display("%0t: radius_fixed expected %0d actual %0d", $time, e.rad, rad);
                errors++;
            end
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    circle_board board = new();
    bit          calm = 1'b0;   // set for the tail of the run: no gaps, no stalls
    bit          sending_done = 1'b0;

    always #5 aclk = ~aclk;

    circumcircle_three_points u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Hand one point triple to the block and hold it until it is taken. The
    // prediction is made at the accepting edge, so the queue stays in order.
    task automatic send_points(coord_t p[6]);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 13);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata <= {p[5], p[4], p[3], p[2], p[1], p[0]};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        board.note_points(p);
        @(negedge aclk);
    endtask

    function automatic coord_t rand_coord();
        return coord_t'($urandom);
    endfunction

    // Random triples: mostly full range, some kept close together, and some
    // built to be collinear or repeated.
    task automatic send_random();
        coord_t p[6];
        int     kind;
        int     bx, by, dx, dy, k;
        kind = $urandom_range(0, 9);
        for (int i = 0; i < 6; i++) p[i] = rand_coord();
        if (kind < 3) begin
            bx = $signed(rand_coord());
            by = $signed(rand_coord());
            for (int i = 0; i < 6; i += 2) begin
                p[i] = coord_t'(bx + $signed($urandom_range(0, 40)) - 20);
                p[i+1] = coord_t'(by + $signed($urandom_range(0, 40)) - 20);
            end
        end else if (kind == 3) begin
            dx = $urandom_range(0, 20) - 10;
            dy = $urandom_range(0, 20) - 10;
            bx = $urandom_range(0, 2000) - 1000;
            by = $urandom_range(0, 2000) - 1000;
            for (int i = 0; i < 3; i++) begin
                k = $urandom_range(0, 200) - 100;
                p[2*i] = coord_t'(bx + k * dx);
                p[2*i+1] = coord_t'(by + k * dy);
            end
        end else if (kind == 4) begin
            p[2] = p[0];
            p[3] = p[1];
        end
        send_points(p);
    endtask

    // Output side: random stalls in bursts, results checked at the edge.
    initial begin
        int stall;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 13);
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            board.check_result(m_tuser, center_t'(m_tdata[23:0]),
                               center_t'(m_tdata[47:24]), radius_t'(m_tdata[78:48]));
        end
    end

    // Stimulus: directed corners first, then random triples.
    initial begin
        coord_t p[6];
        coord_t mx;
        coord_t mn;
        mx = coord_t'(4095);
        mn = coord_t'(-4096);
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // A small right triangle and its mirror.
        p = '{0, 0, 10, 0, 0, 10}; send_points(p);
        p = '{0, 0, -10, 0, 0, -10}; send_points(p);
        // Collinear points, and all three points the same.
        p = '{1, 1, 2, 2, 3, 3}; send_points(p);
        p = '{mn, mn, mn, mn, mn, mn}; send_points(p);
        p = '{mx, mx, mx, mx, mx, mx}; send_points(p);
        // Corners of the coordinate range.
        p = '{mn, mn, mx, mn, mn, mx}; send_points(p);
        p = '{mx, mx, mn, mx, mx, mn}; send_points(p);
        p = '{mn, mx, mx, mx, mx, mn}; send_points(p);
        // Nearly collinear over the full span: the first saturates the center and radius.
        p = '{mn, mn, 0, 0, mx, 4094}; send_points(p);
        p = '{mn, 0, 0, 1, mx, 0}; send_points(p);
        p = '{mn, 0, 0, -1, mx, 0}; send_points(p);
        // Thin triangles give centers with a fraction part of either sign.
        p = '{0, 0, 3, 1, 7, 2}; send_points(p);
        p = '{0, 0, -3, 1, -7, 3}; send_points(p);
        p = '{-1, -1, 2, -3, 5, 4}; send_points(p);
        p = '{mx, 0, 0, mx, mn, 0}; send_points(p);
        p = '{0, mn, mx, 0, 0, mx}; send_points(p);

        for (int n = 0; n < 800; n++) begin
            if (n == 700) calm = 1'b1;
            send_random();
        end
        s_tvalid <= 1'b0;
        sending_done = 1'b1;
    end

    initial begin
        wait (sending_done);
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (PIPE_CYCLES + 20) @(posedge aclk);
        if (board.errors == 0) begin
            $display("circumcircle_three_points: match");
        end else begin
            $display("circumcircle_three_points: mismatch");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("circumcircle_three_points: mismatch");
        $finish;
    end

endmodule
